// ===== rtl/tcmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcmrf_pkg
// Types, codes and sizes shared by the tilt class minimum run filter.
// ----------------------------------------------------------------------------
package tcmrf_pkg;

	// run length counter width and the width used to compare it with a minimum
	localparam int RUN_WIDTH = 16;
	localparam int MIN_WIDTH = 16;
	localparam int CMP_WIDTH = (RUN_WIDTH > MIN_WIDTH) ? RUN_WIDTH : MIN_WIDTH;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CLASS_REST = 2'd0,
		CLASS_POS  = 2'd1,
		CLASS_NEG  = 2'd2,
		CLASS_MID  = 2'd3
	} class_t;

	typedef enum logic [2:0] {
		REG_DEAD_BAND   = 3'd0,
		REG_HIGH_LEVEL  = 3'd1,
		REG_MIN_RUN_REST = 3'd2,
		REG_MIN_RUN_POS = 3'd3,
		REG_MIN_RUN_NEG = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		class_t      class_code;
		logic        run_qualified;
		logic [15:0] event_index;
		logic        stream_end;
	} out_item_t;

	typedef struct packed {
		logic [14:0] dead_band;
		logic [14:0] high_level;
		logic [15:0] min_run_rest;
		logic [15:0] min_run_positive;
		logic [15:0] min_run_negative;
	} cfg_regs_t;

endpackage

// ===== rtl/tilt_class_min_run_filter.sv =====
// ----------------------------------------------------------------------------
// tilt_class_min_run_filter
// Classifies accelerometer samples and reports runs of one class that last
// longer than the minimum set for that class.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  in_data   (sample, last_sample)
//  out      out        out_valid/ out_stall out_data  (class_code, run_qualified,
//                                                      event_index, stream_end)
//  cfg      in         cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A sample enters the input register and is classified and resolved once the
// four-entry queue has room for both its results, which leave one per cycle
// while the output is not stalled. One sample a cycle is taken while the
// queue has room for two results; a sample giving two results takes two entries.
// Reset clears the stream state, the registers and the queue; no sweep.
// A stalled output holds the queue; the input stalls once a sample is held and fewer than two entries are free.
// ----------------------------------------------------------------------------
module tilt_class_min_run_filter import tcmrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_regs_t          cfg_q;
	logic               valid_s1;
	in_item_t           item_s1;
	logic               proc;
	logic               accept;
	logic [1:0]         push_cnt;
	out_item_t          res0;
	out_item_t          res1;
	logic [FIFO_CW-1:0] fifo_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEAD_BAND:    cfg_q.dead_band        <= cfg_data[14:0];
				REG_HIGH_LEVEL:   cfg_q.high_level       <= cfg_data[14:0];
				REG_MIN_RUN_REST: cfg_q.min_run_rest     <= cfg_data;
				REG_MIN_RUN_POS:  cfg_q.min_run_positive <= cfg_data;
				REG_MIN_RUN_NEG:  cfg_q.min_run_negative <= cfg_data;
				default: ;
			endcase
		end
	end

	// resolve the held sample only when the queue can take both its results
	assign proc     = valid_s1 && (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !proc;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	tcmrf_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (proc),
		.item       (item_s1),
		.push_cnt   (push_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	tcmrf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.din0     (res0),
		.din1     (res1),
		.pop      (out_valid && !out_stall),
		.dout     (out_data),
		.count    (fifo_count)
	);

	assign out_valid = fifo_count != '0;

endmodule

// ===== rtl/tcmrf_core.sv =====
// ----------------------------------------------------------------------------
// tcmrf_core
// Sample classifier and run tracker: holds the stream state and forms up to
// two results for each sample it is handed.
// ----------------------------------------------------------------------------
module tcmrf_core import tcmrf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t cfg,
	input  logic      item_valid,
	input  in_item_t  item,
	output logic [1:0] push_cnt,
	output out_item_t res0,
	output out_item_t res1
);

	localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

	class_t               prev_class_q;
	logic                 have_prev_q;
	logic [RUN_WIDTH-1:0] run_len_q;
	logic [15:0]          count_q;

	logic [16:0]          sx;
	logic [16:0]          mag;
	logic                 is_rest;
	logic                 is_over;
	class_t               cls;
	logic                 change;
	logic                 qual_prev;
	logic                 qual_last;
	logic [RUN_WIDTH-1:0] len_next;
	logic [15:0]          count_inc;
	out_item_t            r_change;
	out_item_t            r_close;

	function automatic logic qualifies(class_t c, logic [RUN_WIDTH-1:0] len,
			cfg_regs_t r);
		logic [CMP_WIDTH-1:0] l;
		logic                 q;
		l = CMP_WIDTH'(len);
		unique case (c)
			CLASS_REST: q = l > CMP_WIDTH'(r.min_run_rest);
			CLASS_POS:  q = l > CMP_WIDTH'(r.min_run_positive);
			CLASS_NEG:  q = l > CMP_WIDTH'(r.min_run_negative);
			default:    q = 1'b0;
		endcase
		return q;
	endfunction

	always_comb begin
		// full magnitude, so the most negative sample reads as 32768
		sx      = {item.sample[15], item.sample};
		mag     = item.sample[15] ? (~sx + 17'd1) : sx;
		is_rest = mag <= {2'b00, cfg.dead_band};
		is_over = mag > {2'b00, cfg.high_level};
		priority if (is_rest) begin
			cls = CLASS_REST;
		end else if (is_over && !item.sample[15]) begin
			cls = CLASS_POS;
		end else if (is_over) begin
			cls = CLASS_NEG;
		end else begin
			cls = CLASS_MID;
		end

		change    = have_prev_q && (cls != prev_class_q);
		qual_prev = change && qualifies(prev_class_q, run_len_q, cfg);
		if (change) begin
			len_next = RUN_WIDTH'(1);
		end else if (run_len_q != RUN_MAX) begin
			len_next = run_len_q + RUN_WIDTH'(1);
		end else begin
			len_next = run_len_q;
		end
		count_inc = (count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;
		qual_last = qualifies(cls, len_next, cfg);

		r_change.class_code    = prev_class_q;
		r_change.run_qualified = 1'b1;
		r_change.event_index   = count_q;
		r_change.stream_end    = 1'b0;

		r_close.class_code    = qual_last ? cls : CLASS_REST;
		r_close.run_qualified = qual_last;
		r_close.event_index   = qual_prev ? count_inc : count_q;
		r_close.stream_end    = 1'b1;

		push_cnt = item_valid ? ({1'b0, qual_prev} + {1'b0, item.last_sample}) : 2'd0;
		res0     = qual_prev ? r_change : r_close;
		res1     = r_close;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= CLASS_REST;
			have_prev_q  <= 1'b0;
			run_len_q    <= '0;
			count_q      <= '0;
		end else if (item_valid) begin
			if (item.last_sample) begin
				// close the stream and start afresh
				prev_class_q <= CLASS_REST;
				have_prev_q  <= 1'b0;
				run_len_q    <= '0;
				count_q      <= '0;
			end else begin
				prev_class_q <= cls;
				have_prev_q  <= 1'b1;
				run_len_q    <= len_next;
				count_q      <= qual_prev ? count_inc : count_q;
			end
		end
	end

endmodule

// ===== rtl/tcmrf_fifo.sv =====
// ----------------------------------------------------------------------------
// tcmrf_fifo
// Small result queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module tcmrf_fifo import tcmrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  out_item_t          din0,
	input  out_item_t          din1,
	input  logic               pop,
	output out_item_t          dout,
	output logic [FIFO_CW-1:0] count
);

	out_item_t          slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic [FIFO_AW-1:0] wptr_p1;

	assign wptr_p1 = wptr_q + FIFO_AW'(1);
	assign dout    = slot_q[rptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			slot_q[wptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			slot_q[wptr_p1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_AW'(push_cnt);
			rptr_q  <= rptr_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
		end
	end

endmodule

// ===== rtl/tcmrf_checker.sv =====
// ----------------------------------------------------------------------------
// tcmrf_sva
// Port-level checks for the tilt class minimum run filter.
// ----------------------------------------------------------------------------
module tcmrf_sva import tcmrf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// input back-pressure only comes from a backed-up result queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_no_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.class_code != CLASS_MID)
		else $error("middle band reported");

	// an unqualified result is only the plain closing request
	a_plain_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.run_qualified |->
			out_data.stream_end && out_data.class_code == CLASS_REST)
		else $error("unqualified result that is not a closing request");

endmodule

bind tilt_class_min_run_filter tcmrf_sva u_tcmrf_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
